// ===== src/tlcr_pkg.sv =====
// Package for the text line cell renderer: field widths, byte codes, op and
// kind codes, sequencer states and the structs passed between its modules.
// No dependencies.
package tlcr_pkg;

  localparam int unsigned ROW_W   = 6;
  localparam int unsigned COL_W   = 13;  // signed cursor column
  localparam int unsigned ORG_W   = 12;  // signed line start column
  localparam int unsigned WIDTH_W = 9;   // effective width, up to 255
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SCOL_W  = 8;   // screen column on the output
  localparam int unsigned TAB_W   = 3;   // tab stops every 8 columns

  localparam logic [7:0]         SCREEN_WIDTH_RESET = 8'd80;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH          = 9'd2;

  // input op codes
  localparam logic [1:0] OP_SET_POS = 2'd0;
  localparam logic [1:0] OP_PUT_CHR = 2'd1;
  localparam logic [1:0] OP_ERASE   = 2'd2;

  // result kinds
  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL      = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_DOLLAR   = 8'h24;
  localparam logic [CHAR_W-1:0] CH_CARET    = 8'h5E;
  localparam logic [CHAR_W-1:0] CTRL_FLIP   = 8'h40;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PRINT = 6'b000010,
    S_CARET = 6'b000100,
    S_CTRL  = 6'b001000,
    S_TAB   = 6'b010000,
    S_ERASE = 6'b100000
  } seq_state_e;

  // one cell step: request to the shared unit
  typedef struct packed {
    logic signed [COL_W-1:0] column;
    logic [WIDTH_W-1:0]      width;
    logic [CHAR_W-1:0]       ch;
    logic                    erase;
  } step_req_t;

  // one cell step: answer of the shared unit
  typedef struct packed {
    logic                    emit;
    logic                    ovf;
    logic [SCOL_W-1:0]       column;
    logic [CHAR_W-1:0]       ch;
    logic signed [COL_W-1:0] col_next;
  } step_rsp_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [SCOL_W-1:0] column;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } result_t;

endpackage

// ===== src/text_line_cell_renderer_unit.sv =====
// Text line cell renderer, top level.
// Depends on tlcr_pkg, tlcr_seq and tlcr_cell_step.
//
// Input stream (s_axis): tuser carries the op, tdata the position and byte.
// A set-position item is taken and gives no result. A put character or
// erase item holds tready low while the sequencer walks its cells, one
// cell step per cycle through the shared step unit while the output
// register is free: a printable byte or an erase takes 1 step, a control
// byte 2, a tab 1 to 8. The item is accepted in the idle state before.
// Results (m_axis) leave from an output register in the cycle after their
// step; tuser is the kind, tlast marks the final result of an item, and an
// item whose cells all fall left of column 0 gives none.
// When the receiver stalls, the step that would replace a waiting result
// waits with it; a new item is taken while the final result still waits.
// Reset clears the cursor to row 0, column 0, sets the width to 80 and
// drops any waiting result. cfg_we_i writes screen_width (clamped to 2..255)
// and is meant to be used only while no item is in flight.
module text_line_cell_renderer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // screen_width
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // line_row[5:0], start_column[17:6], symbol[25:18]
  input  logic [1:0]  s_axis_tuser,    // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // cell_row[5:0], cell_column[13:6], cell_char[21:14]
  output logic        m_axis_tuser,    // kind[0]
  output logic        m_axis_tlast     // last
);

  logic [7:0]                     width_q;
  logic [tlcr_pkg::WIDTH_W-1:0]   eff_width;
  logic                           out_valid_q, out_valid_d;
  tlcr_pkg::result_t              out_q;
  tlcr_pkg::result_t              res;
  logic                           res_valid;
  logic                           out_free;

  assign eff_width = ({1'b0, width_q} < tlcr_pkg::MIN_WIDTH) ? tlcr_pkg::MIN_WIDTH
                                                             : {1'b0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= tlcr_pkg::SCREEN_WIDTH_RESET;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  tlcr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .row_i       (s_axis_tdata[5:0]),
    .start_i     (s_axis_tdata[17:6]),
    .symbol_i    (s_axis_tdata[25:18]),
    .width_i     (eff_width),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid)          out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.ch, out_q.column, out_q.row};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  // a result still waiting once the block is idle must close its item
  a_idle_pending_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("result waiting at idle without tlast");

  // a clear command is the only result of its item
  a_clear_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tlcr_pkg::KIND_CLEAR) |-> m_axis_tlast)
    else $error("clear command without tlast");

  // set position leaves the block ready for the next item
  a_setpos_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == tlcr_pkg::OP_SET_POS)
    |=> s_axis_tready)
    else $error("set position left the block busy");

endmodule

// ===== src/tlcr_cell_step.sv =====
// Shared cell step unit: one compare against the width and one increment,
// giving a cell write, an overflow '$' or a clear command.
// Depends on tlcr_pkg.
module tlcr_cell_step (
  input  tlcr_pkg::step_req_t req_i,
  output tlcr_pkg::step_rsp_t rsp_o
);

  logic signed [tlcr_pkg::COL_W-1:0] width_s;
  logic [tlcr_pkg::WIDTH_W-1:0]      width_m1;
  logic                              ovf;
  logic                              visible;

  assign width_s  = $signed({{(tlcr_pkg::COL_W-tlcr_pkg::WIDTH_W){1'b0}}, req_i.width});
  assign width_m1 = req_i.width - tlcr_pkg::WIDTH_W'(1);
  assign ovf      = req_i.column >= width_s;
  assign visible  = !req_i.column[tlcr_pkg::COL_W-1];

  always_comb begin
    rsp_o.ovf = ovf;
    if (req_i.erase) begin
      // clear from the cursor, clamped to column 0, then park at the width
      rsp_o.emit     = !ovf;
      rsp_o.column   = visible ? req_i.column[tlcr_pkg::SCOL_W-1:0] : '0;
      rsp_o.ch       = tlcr_pkg::CH_SPACE;
      rsp_o.col_next = width_s;
    end else begin
      rsp_o.emit     = ovf || visible;
      rsp_o.column   = ovf ? width_m1[tlcr_pkg::SCOL_W-1:0]
                           : req_i.column[tlcr_pkg::SCOL_W-1:0];
      rsp_o.ch       = ovf ? tlcr_pkg::CH_DOLLAR : req_i.ch;
      rsp_o.col_next = ovf ? width_s : req_i.column + tlcr_pkg::COL_W'(1);
    end
  end

endmodule

// ===== src/tlcr_seq.sv =====
// Sequencer of the renderer: cursor state, item decode and one cell step
// per cycle through the shared step unit while the output register is free.
// Depends on tlcr_pkg and tlcr_cell_step.
module tlcr_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [tlcr_pkg::ROW_W-1:0]    row_i,
  input  logic [tlcr_pkg::ORG_W-1:0]    start_i,
  input  logic [tlcr_pkg::CHAR_W-1:0]   symbol_i,
  input  logic [tlcr_pkg::WIDTH_W-1:0]  width_i,
  input  logic                          out_free_i,
  output logic                          res_valid_o,
  output tlcr_pkg::result_t             res_o
);

  tlcr_pkg::seq_state_e state_q, state_d;
  logic signed [tlcr_pkg::COL_W-1:0] col_q, col_d;
  logic [tlcr_pkg::ORG_W-1:0]        origin_q, origin_d;
  logic [tlcr_pkg::ROW_W-1:0]        row_q, row_d;
  logic [tlcr_pkg::CHAR_W-1:0]       sym_q, sym_d;

  tlcr_pkg::step_req_t req;
  tlcr_pkg::step_rsp_t rsp;
  logic                step_en;
  logic                accept;
  logic                tab_done;
  logic                last;
  logic                is_ctrl;
  logic [tlcr_pkg::TAB_W-1:0] tab_pos;

  tlcr_cell_step u_step (
    .req_i (req),
    .rsp_o (rsp)
  );

  assign in_ready_o = (state_q == tlcr_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign step_en    = !in_ready_o && out_free_i;

  assign is_ctrl = (symbol_i < tlcr_pkg::CH_SPACE && symbol_i != tlcr_pkg::CH_TAB)
                   || symbol_i == tlcr_pkg::CH_DEL;

  // tab stop is relative to the start column of the line
  assign tab_pos  = rsp.col_next[tlcr_pkg::TAB_W-1:0] - origin_q[tlcr_pkg::TAB_W-1:0];
  assign tab_done = rsp.ovf || (tab_pos == '0);

  always_comb begin
    req.column = col_q;
    req.width  = width_i;
    req.erase  = 1'b0;
    req.ch     = sym_q;
    last       = 1'b1;
    unique case (state_q)
      tlcr_pkg::S_CARET: begin
        req.ch = tlcr_pkg::CH_CARET;
        last   = 1'b0;  // the second cell always follows a visible caret
      end
      tlcr_pkg::S_CTRL:  req.ch = sym_q ^ tlcr_pkg::CTRL_FLIP;
      tlcr_pkg::S_TAB: begin
        req.ch = tlcr_pkg::CH_SPACE;
        last   = tab_done;
      end
      tlcr_pkg::S_ERASE: begin
        req.ch    = tlcr_pkg::CH_SPACE;
        req.erase = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_valid_o = step_en && rsp.emit;
  assign res_o.kind   = req.erase ? tlcr_pkg::KIND_CLEAR : tlcr_pkg::KIND_CELL;
  assign res_o.row    = row_q;
  assign res_o.column = rsp.column;
  assign res_o.ch     = rsp.ch;
  assign res_o.last   = last;

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    origin_d = origin_q;
    row_d    = row_q;
    sym_d    = sym_q;
    if (accept) begin
      unique case (op_i)
        tlcr_pkg::OP_SET_POS: begin
          row_d    = row_i;
          col_d    = $signed({start_i[tlcr_pkg::ORG_W-1], start_i});
          origin_d = start_i;
        end
        tlcr_pkg::OP_PUT_CHR: begin
          sym_d = symbol_i;
          priority if (symbol_i == tlcr_pkg::CH_TAB) state_d = tlcr_pkg::S_TAB;
          else if (is_ctrl)                          state_d = tlcr_pkg::S_CARET;
          else                                       state_d = tlcr_pkg::S_PRINT;
        end
        tlcr_pkg::OP_ERASE: state_d = tlcr_pkg::S_ERASE;
        default: ;
      endcase
    end else if (step_en) begin
      col_d = rsp.col_next;
      unique case (state_q)
        tlcr_pkg::S_CARET: state_d = tlcr_pkg::S_CTRL;
        tlcr_pkg::S_TAB:   state_d = tab_done ? tlcr_pkg::S_IDLE : tlcr_pkg::S_TAB;
        default:           state_d = tlcr_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tlcr_pkg::S_IDLE;
      col_q    <= '0;
      origin_q <= '0;
      row_q    <= '0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      origin_q <= origin_d;
      row_q    <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

endmodule

// ===== test/tb_text_line_cell_renderer_unit.sv =====
// Self-checking testbench for text_line_cell_renderer_unit: a directed table, then random
// line sequences at several screen widths, checked against a cycle-free cell predictor.
// Depends on tlcr_pkg and the renderer RTL.
`timescale 1ns / 1ps

module tb_text_line_cell_renderer_unit;

  localparam int PRED           = -1;   // row checked against the predictor
  localparam int NUM_PHASES     = 6;
  localparam int RAND_PER_PHASE = 74;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int MAX_WIDTH      = 256;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  text_line_cell_renderer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0] scr_width;
  logic [5:0] cur_row;
  int         cur_col;
  int         line_org;

  tlcr_pkg::result_t item_cells[$];      // cells caused by the item just accepted
  tlcr_pkg::result_t expected_cells[$];  // cells still owed by the block

  int errors        = 0;
  int items_sent    = 0;
  int cells_checked = 0;
  int quiet_cycles  = 0;
  int burst_left    = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;

  function automatic int eff_width();
    int w;
    w = scr_width;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic void add_cell(logic kind, int col, logic [7:0] ch);
    tlcr_pkg::result_t c;
    c.kind   = kind;
    c.row    = cur_row;
    c.column = col[7:0];
    c.ch     = ch;
    c.last   = 1'b0;
    item_cells.push_back(c);
  endfunction

  // one cell at the cursor; returns 1 once the row has overflowed
  function automatic bit put_cell(logic [7:0] ch);
    int w;
    w = eff_width();
    if (cur_col >= w) begin
      add_cell(tlcr_pkg::KIND_CELL, w - 1, tlcr_pkg::CH_DOLLAR);
      cur_col = w;
      return 1'b1;
    end
    if (cur_col >= 0) add_cell(tlcr_pkg::KIND_CELL, cur_col, ch);
    cur_col++;
    return 1'b0;
  endfunction

  function automatic void render_item(logic [1:0] op, logic [5:0] row,
                                      logic signed [11:0] scol, logic [7:0] sym);
    int w;
    item_cells.delete();
    case (op)
      tlcr_pkg::OP_SET_POS: begin
        cur_row  = row;
        cur_col  = scol;
        line_org = scol;
      end
      tlcr_pkg::OP_PUT_CHR: begin
        if (sym == tlcr_pkg::CH_TAB) begin
          do begin
            if (put_cell(tlcr_pkg::CH_SPACE)) break;
          end while (((cur_col - line_org) & 7) != 0);
        end else if (sym < tlcr_pkg::CH_SPACE || sym == tlcr_pkg::CH_DEL) begin
          void'(put_cell(tlcr_pkg::CH_CARET));
          void'(put_cell(sym ^ tlcr_pkg::CTRL_FLIP));
        end else begin
          void'(put_cell(sym));
        end
      end
      tlcr_pkg::OP_ERASE: begin
        w = eff_width();
        if (cur_col < w)
          add_cell(tlcr_pkg::KIND_CLEAR, (cur_col < 0) ? 0 : cur_col, tlcr_pkg::CH_SPACE);
        cur_col = w;
      end
      default: ;
    endcase
    if (item_cells.size() > 0) item_cells[item_cells.size() - 1].last = 1'b1;
  endfunction

  // offers one item in bursts with random gaps; typed_n < 0 uses the predictor
  task automatic send_item(logic [1:0] op, logic [5:0] row, logic signed [11:0] scol,
                           logic [7:0] sym, int typed_n, tlcr_pkg::result_t typed);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, sym, scol, row};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    render_item(op, row, scol, sym);
    if (typed_n < 0) begin
      foreach (item_cells[i]) expected_cells.push_back(item_cells[i]);
    end else if (typed_n > 0) begin
      expected_cells.push_back(typed);
    end
  endtask

  // width change only with nothing in flight
  task automatic set_width(logic [7:0] w);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    scr_width = w;
  endtask

  // receiver: mixed stall patterns, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    int tick;
    mode = 0;
    span = 0;
    tick = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(4, 60);
        end
        span--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // output checker and activity counter
  always @(posedge clk_i) begin : cell_checker
    tlcr_pkg::result_t want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      cells_checked++;
      if (expected_cells.size() == 0) begin
        $error("unexpected cell transfer: tdata %h tuser %b tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[5:0] !== want.row) begin
          $error("cell_row: expected %0d, actual %0d", want.row, m_axis_tdata[5:0]);
          errors++;
        end
        if (m_axis_tdata[13:6] !== want.column) begin
          $error("cell_column: expected %0d, actual %0d", want.column, m_axis_tdata[13:6]);
          errors++;
        end
        if (m_axis_tdata[21:14] !== want.ch) begin
          $error("cell_char: expected %h, actual %h", want.ch, m_axis_tdata[21:14]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("watchdog: no transfer for %0d cycles, %0d cells outstanding",
             quiet_cycles, expected_cells.size());
    $display("TEST FAILED");
    $finish;
  end

  typedef struct {
    logic [1:0]         op;
    logic [5:0]         row;
    logic signed [11:0] scol;
    logic [7:0]         sym;
    int                 n;      // PRED, or number of typed cells (0 or 1)
    logic               ekind;
    logic [5:0]         erow;
    logic [7:0]         ecol;
    logic [7:0]         ech;
  } dir_row_t;

  // width 80 throughout; unused fields carry junk
  dir_row_t dir_tbl [0:23] = '{
    '{tlcr_pkg::OP_PUT_CHR, 6'd63, -12'sd2048, 8'h41, 1, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h41},
    '{tlcr_pkg::OP_SET_POS, 6'd63, 12'sd0, 8'hFF, 0, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, -12'sd1, 8'hFF, 1, tlcr_pkg::KIND_CELL, 6'd63, 8'd0, 8'hFF},
    '{tlcr_pkg::OP_PUT_CHR, 6'd7, 12'sd0, 8'h7E, 1, tlcr_pkg::KIND_CELL, 6'd63, 8'd1, 8'h7E},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h20, 1, tlcr_pkg::KIND_CELL, 6'd63, 8'd2, 8'h20},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h09, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h00, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h7F, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h1F, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h80, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_ERASE, 6'd0, 12'sd0, 8'h00, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_ERASE, 6'd0, 12'sd0, 8'h00, 0, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h78, 1, tlcr_pkg::KIND_CELL, 6'd63, 8'd79, 8'h24},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h09, 1, tlcr_pkg::KIND_CELL, 6'd63, 8'd79, 8'h24},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h01, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_SET_POS, 6'd5, -12'sd2048, 8'h00, 0, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h09, 0, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h42, 0, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_ERASE, 6'd0, 12'sd0, 8'h00, 1, tlcr_pkg::KIND_CLEAR, 6'd5, 8'd0, 8'h20},
    '{tlcr_pkg::OP_SET_POS, 6'd10, -12'sd1, 8'h00, 0, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h02, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_SET_POS, 6'd42, -12'sd3, 8'h00, 0, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_PUT_CHR, 6'd0, 12'sd0, 8'h09, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00},
    '{tlcr_pkg::OP_ERASE, 6'd0, 12'sd0, 8'h00, PRED, tlcr_pkg::KIND_CELL, 6'd0, 8'd0, 8'h00}
  };

  initial begin : stimulus
    tlcr_pkg::result_t  tw;
    logic [7:0]         ph_width [NUM_PHASES];
    logic [1:0]         op;
    logic [5:0]         row;
    logic signed [11:0] sc;
    logic [7:0]         sym;
    int                 run_left;
    int                 pick;
    int                 cls;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tlcr_pkg::OP_SET_POS;

    scr_width = tlcr_pkg::SCREEN_WIDTH_RESET;
    cur_row   = '0;
    cur_col   = 0;
    line_org  = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      tw.kind   = dir_tbl[i].ekind;
      tw.row    = dir_tbl[i].erow;
      tw.column = dir_tbl[i].ecol;
      tw.ch     = dir_tbl[i].ech;
      tw.last   = 1'b1;
      send_item(dir_tbl[i].op, dir_tbl[i].row, dir_tbl[i].scol, dir_tbl[i].sym,
                dir_tbl[i].n, tw);
    end

    ph_width[0] = 8'd255;
    ph_width[1] = 8'd2;
    ph_width[2] = 8'($urandom_range(3, 254));
    ph_width[3] = 8'd8;
    ph_width[4] = 8'($urandom_range(3, 254));
    ph_width[5] = tlcr_pkg::SCREEN_WIDTH_RESET;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_width(ph_width[ph]);
      run_left = 0;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        // long receiver stall while the sender keeps offering
        if (ph == 0 && k == RAND_PER_PHASE / 2) hold_req = 1'b1;
        row  = 6'($urandom_range(0, 63));
        sc   = 12'(0 - $urandom_range(0, 2048));
        sym  = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (run_left == 0) begin
          op   = tlcr_pkg::OP_SET_POS;
          cls  = $urandom_range(0, 9);
          if (cls < 6) sc = 12'sd0;
          else if (cls < 9) sc = 12'(0 - $urandom_range(1, 40));
          run_left = $urandom_range(1, 30);
        end else if (pick < 5) begin
          op = (pick < 3) ? tlcr_pkg::OP_ERASE : tlcr_pkg::OP_SET_POS;
        end else begin
          run_left--;
          op = (run_left == 0 && $urandom_range(0, 1) == 1) ? tlcr_pkg::OP_ERASE
                                                            : tlcr_pkg::OP_PUT_CHR;
          cls = $urandom_range(0, 19);
          if (cls < 10) sym = 8'($urandom_range(32, 126));
          else if (cls < 13) sym = tlcr_pkg::CH_TAB;
          else if (cls < 16) sym = ($urandom_range(0, 32) == 32) ? tlcr_pkg::CH_DEL
                                                                 : 8'($urandom_range(0, 31));
          else sym = 8'($urandom_range(128, 255));
        end
        send_item(op, row, sc, sym, PRED, '0);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d input items and %0d cell transfers over %0d width settings,",
             items_sent, cells_checked, NUM_PHASES + 1);
    $display("including tabs, control bytes, hidden cells, overflow and a long output stall.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
